// ===== hw/rtl/lbi_pkg.sv =====
// Shared types and constants for the label bitmap index.
// No dependencies; compile first.
package lbi_pkg;

  localparam int NODE_W  = 12;
  localparam int LABEL_W = 8;
  localparam int WIDX_W  = 6;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } lbi_state_t;

  typedef enum logic {
    ACT_MARK = 1'b0,
    ACT_SCAN = 1'b1
  } lbi_action_t;

endpackage

// ===== hw/rtl/lbi_if.sv =====
// Valid/ready channel interfaces for the label bitmap index.
// Depends on lbi_pkg for field widths.
interface lbi_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [lbi_pkg::LABEL_W-1:0] label;
  logic [lbi_pkg::NODE_W-1:0]  node;
  logic [lbi_pkg::WIDX_W-1:0]  word_index;

  modport source (output valid, action, label, node, word_index, input ready);
  modport sink   (input valid, action, label, node, word_index, output ready);
endinterface

interface lbi_out_if;
  logic                      valid;
  logic                      ready;
  logic [lbi_pkg::NODE_W-1:0] node_id;
  logic                      found;
  logic                      last;

  modport source (output valid, node_id, found, last, input ready);
  modport sink   (input valid, node_id, found, last, output ready);
endinterface

// ===== hw/rtl/lbi_lowbit.sv =====
// Find-lowest-set and clear-lowest-set unit for one bitmap word.
// Purely combinational; no package dependency.
module lbi_lowbit #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]          vec,
  output logic [$clog2(WORD_BITS)-1:0]  pos,
  output logic [WORD_BITS-1:0]          rest
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] iso;

  assign iso  = vec & (~vec + WORD_BITS'(1));
  assign rest = vec & (vec - WORD_BITS'(1));

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/label_bitmap_index_top.sv =====
// Label bitmap index: per-label node membership bitmaps with set and word scan.
// Depends on lbi_pkg, lbi_if and lbi_lowbit.
//
// Usage:
//   in_ch  carries one transaction per request: action 0 marks node under label,
//          action 1 scans word word_index of the label's row.
//   out_ch carries the results: one acknowledge per mark (found cleared when
//          label or node is out of range), one result per marked node in the
//          scanned word lowest first, or one result with found cleared when the
//          word is empty or out of range. last flags the final result.
// Timing:
//   After reset the block sweeps the bitmap store, one word per cycle, through
//   all NUM_LABELS * NUM_NODES / WORD_BITS words (16384 by default); in_ch.ready
//   stays low during the sweep.
//   The block holds one request at a time. A mark reads the store word, then
//   writes it back with the acknowledge. A scan reads the word, then, unless
//   out_ch stalls, takes one find-lowest-set step per cycle in the shared unit.
//   Results leave through an output register; a stall on out_ch holds the
//   sequencer and the pending result until the transaction completes.
module label_bitmap_index_top #(
  parameter int NUM_LABELS = 256,
  parameter int NUM_NODES  = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lbi_in_if.sink    in_ch,
  lbi_out_if.source out_ch
);

  localparam int    WPR         = NUM_NODES / WORD_BITS;
  localparam longint STORE_DEPTH = longint'(NUM_LABELS) * longint'(WPR);
  localparam int    ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int    BIT_W       = $clog2(WORD_BITS);
  localparam int    NODE_W      = lbi_pkg::NODE_W;

  logic [WORD_BITS-1:0] bitmap_mem [STORE_DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  lbi_pkg::lbi_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [WORD_BITS-1:0] pending_r, pending_nxt;

  logic                 action_r;
  logic [NODE_W-1:0]    node_r;
  logic [NODE_W-1:0]    base_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [BIT_W-1:0]     bit_r;
  logic                 hit_r;

  logic                 out_valid_r;
  logic [NODE_W-1:0]    out_node_id_r;
  logic                 out_found_r;
  logic                 out_last_r;

  logic                 in_ready;
  logic                 accept;
  logic                 out_free;
  logic                 set_hit, scan_hit, req_hit;
  logic [ADDR_W-1:0]    set_addr, scan_addr, req_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 emit, emit_found, emit_last;
  logic [NODE_W-1:0]    emit_node;
  logic [BIT_W-1:0]     low_pos;
  logic [WORD_BITS-1:0] low_rest;

  lbi_lowbit #(.WORD_BITS(WORD_BITS)) u_lowbit (
    .vec  (pending_r),
    .pos  (low_pos),
    .rest (low_rest)
  );

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign set_hit  = (32'(in_ch.label) < NUM_LABELS) && (32'(in_ch.node) < NUM_NODES);
  assign scan_hit = (32'(in_ch.label) < NUM_LABELS) && (32'(in_ch.word_index) < WPR);
  assign set_addr = ADDR_W'(in_ch.label) * ADDR_W'(WPR)
                  + ADDR_W'(32'(in_ch.node) / WORD_BITS);
  assign scan_addr = ADDR_W'(in_ch.label) * ADDR_W'(WPR) + ADDR_W'(in_ch.word_index);
  assign req_hit  = (in_ch.action == lbi_pkg::ACT_SCAN) ? scan_hit : set_hit;
  assign req_addr = (in_ch.action == lbi_pkg::ACT_SCAN) ? scan_addr : set_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (accept && req_hit) begin
      rd_data_r <= bitmap_mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_ch.action;
      node_r   <= in_ch.node;
      base_r   <= NODE_W'(32'(in_ch.word_index) * WORD_BITS);
      addr_r   <= req_addr;
      bit_r    <= BIT_W'(32'(in_ch.node) % WORD_BITS);
      hit_r    <= req_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lbi_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      pending_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pending_nxt = pending_r;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = rd_data_r | (WORD_BITS'(1) << bit_r);
    emit        = 1'b0;
    emit_node   = node_r;
    emit_found  = 1'b0;
    emit_last   = 1'b1;
    unique case (state_r)
      lbi_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = lbi_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      lbi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = lbi_pkg::ST_EXEC;
        end
      end
      lbi_pkg::ST_EXEC: begin
        if (action_r == lbi_pkg::ACT_MARK) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_found = hit_r;
            mem_we     = hit_r;
            state_nxt  = lbi_pkg::ST_IDLE;
          end
        end else begin
          pending_nxt = hit_r ? rd_data_r : '0;
          state_nxt   = lbi_pkg::ST_SCAN;
        end
      end
      lbi_pkg::ST_SCAN: begin
        if (out_free) begin
          emit = 1'b1;
          if (pending_r == '0) begin
            emit_node = '0;
            state_nxt = lbi_pkg::ST_IDLE;
          end else begin
            emit_node   = base_r + NODE_W'(low_pos);
            emit_found  = 1'b1;
            emit_last   = (low_rest == '0);
            pending_nxt = low_rest;
            if (low_rest == '0) begin
              state_nxt = lbi_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = lbi_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_node_id_r <= emit_node;
      out_found_r   <= emit_found;
      out_last_r    <= emit_last;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.node_id = out_node_id_r;
  assign out_ch.found   = out_found_r;
  assign out_ch.last    = out_last_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbi_pkg::ST_CLEAR) |-> !in_ch.ready)
    else $error("transaction accepted during store sweep");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == lbi_pkg::ST_EXEC))
    else $error("accepted transaction not executed");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == lbi_pkg::ST_CLEAR) ||
                ((state_r == lbi_pkg::ST_EXEC) && (action_r == lbi_pkg::ACT_MARK) && hit_r)))
    else $error("unexpected store write");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == lbi_pkg::ST_IDLE))
    else $error("final result did not end the item");

  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result emitted over a held result");
`endif

endmodule
